// ===== design/kmr_pkg.sv =====
// Package for the key macro recorder and replayer.
// Holds action and result codes, register defaults, the controller/datapath
// command and status structs and the key-state decode helpers. No dependencies.
`timescale 1ns / 1ps

package kmr_pkg;

   // Store depth default and fixed field widths.
   localparam int STORE_DEPTH_DEFAULT = 32;
   localparam int REQ_DATA_WIDTH      = 48;
   localparam int RSP_DATA_WIDTH      = 64;
   localparam int CSR_ADDR_WIDTH      = 5;
   localparam int CSR_DATA_WIDTH      = 32;

   // Input action codes.
   localparam logic [3:0] ACT_KEY_EVENT   = 4'd0;
   localparam logic [3:0] ACT_TICK        = 4'd1;
   localparam logic [3:0] ACT_START_REC   = 4'd2;
   localparam logic [3:0] ACT_STOP_REC    = 4'd3;
   localparam logic [3:0] ACT_TOGGLE_REC  = 4'd4;
   localparam logic [3:0] ACT_REPLAY      = 4'd5;
   localparam logic [3:0] ACT_ABORT       = 4'd6;
   localparam logic [3:0] ACT_TOGGLE_PLAY = 4'd7;
   localparam logic [3:0] ACT_RESET_REP   = 4'd8;
   localparam logic [3:0] ACT_DIGIT       = 4'd9;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_CAPACITY    = 3'd0;
   localparam logic [2:0] REG_MAX_REPEATS = 3'd1;
   localparam logic [2:0] REG_PRESSED     = 3'd2;
   localparam logic [2:0] REG_WAS_PRESSED = 3'd3;
   localparam logic [2:0] REG_INJECTED    = 3'd4;

   // Register reset values.
   localparam logic [5:0]  CAPACITY_RESET    = 6'd32;
   localparam logic [15:0] MAX_REPEATS_RESET = 16'd99;
   localparam logic [7:0]  PRESSED_RESET     = 8'd1;
   localparam logic [7:0]  WAS_PRESSED_RESET = 8'd2;
   localparam logic [7:0]  INJECTED_RESET    = 8'd128;

   // Largest single digit of the decimal repeat count entry.
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_EVENT   = 2'd2
   } kind_type;

   // One stored key event.
   typedef struct packed {
      logic [15:0] code;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  st;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     cap_item;
      logic     set_rec;
      logic     clr_rec;
      logic     set_play;
      logic     clr_play;
      logic     cnt_clear;
      logic     cnt_dec;
      logic     rep_clear;
      logic     rep_dec;
      logic     rep_min1;
      logic     rep_digit;
      logic     wr_event;
      logic     wr_synth;
      logic     rd_tail;
      logic     rd_play;
      logic     ptr_clear;
      logic     out_load;
      kind_type out_kind;
      logic     out_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [3:0] action;
      logic       enabled;
      logic       rec;
      logic       play;
      logic       rep_zero;
      logic       count_zero;
      logic       item_press;
      logic       item_release;
      logic       item_injected;
      logic       stop_due;
      logic       tail_press;
      logic       play_done;
      logic       out_free;
   } status_type;

   // A press has some pressed bit and no was-pressed bit.
   function automatic logic is_press(logic [7:0] s, logic [7:0] pm, logic [7:0] wm);
      return (|(s & pm)) && !(|(s & wm));
   endfunction

   // A release has no pressed bit and some was-pressed bit.
   function automatic logic is_release(logic [7:0] s, logic [7:0] pm, logic [7:0] wm);
      return !(|(s & pm)) && (|(s & wm));
   endfunction

endpackage

// ===== design/kmr_ctrl.sv =====
// Controller state machine of the key macro recorder and replayer.
// Decodes each accepted action and sequences store writes, trimming and replay.
// Depends on kmr_pkg for the command and status structs and the action codes.
`timescale 1ns / 1ps

module kmr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  kmr_pkg::status_type status,
   output kmr_pkg::cmd_type    cmd
);
   import kmr_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE       = 11'b000_0000_0001,
      S_EXEC       = 11'b000_0000_0010,
      S_WR2        = 11'b000_0000_0100,
      S_STOPCHK    = 11'b000_0000_1000,
      S_TRIM_RD    = 11'b000_0001_0000,
      S_TRIM_CHK   = 11'b000_0010_0000,
      S_EMIT_STAT  = 11'b000_0100_0000,
      S_PLAY_MARK1 = 11'b000_1000_0000,
      S_PLAY_RD    = 11'b001_0000_0000,
      S_PLAY_OUT   = 11'b010_0000_0000,
      S_PLAY_MARK2 = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_kind = KIND_STATUS;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.cap_item = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_EMIT_STAT;
            if (status.enabled) begin
               unique case (status.action)
                  ACT_KEY_EVENT: begin
                     if ((status.item_press || status.item_release) && status.rec &&
                         !(status.count_zero && status.item_release)) begin
                        cmd.wr_event = 1'b1;
                        state_in = (status.item_press && status.item_injected) ?
                                   S_WR2 : S_STOPCHK;
                     end
                  end
                  ACT_TICK: begin
                     if (status.play) begin
                        if (!status.rep_zero) begin
                           cmd.rep_dec = 1'b1;
                           state_in    = S_PLAY_MARK1;
                        end else if (!status.rec) begin
                           cmd.clr_play  = 1'b1;
                           cmd.rep_clear = 1'b1;
                        end
                     end
                  end
                  ACT_START_REC: begin
                     if (!status.rec && !status.play) begin
                        cmd.set_rec   = 1'b1;
                        cmd.cnt_clear = 1'b1;
                     end
                  end
                  ACT_STOP_REC: begin
                     if (status.rec && !status.play) begin
                        cmd.clr_rec = 1'b1;
                        state_in    = S_TRIM_RD;
                     end
                  end
                  ACT_TOGGLE_REC: begin
                     if (!status.play) begin
                        if (status.rec) begin
                           cmd.clr_rec = 1'b1;
                           state_in    = S_TRIM_RD;
                        end else begin
                           cmd.set_rec   = 1'b1;
                           cmd.cnt_clear = 1'b1;
                        end
                     end
                  end
                  ACT_REPLAY: begin
                     if (!status.rec && !status.play) begin
                        cmd.set_play = 1'b1;
                        cmd.rep_min1 = 1'b1;
                     end
                  end
                  ACT_ABORT: begin
                     if (!status.rec && status.play) begin
                        cmd.clr_play  = 1'b1;
                        cmd.rep_clear = 1'b1;
                     end
                  end
                  ACT_TOGGLE_PLAY: begin
                     if (!status.rec) begin
                        if (status.play) begin
                           cmd.clr_play  = 1'b1;
                           cmd.rep_clear = 1'b1;
                        end else begin
                           cmd.set_play = 1'b1;
                           cmd.rep_min1 = 1'b1;
                        end
                     end
                  end
                  ACT_RESET_REP: begin
                     cmd.rep_clear = 1'b1;
                  end
                  ACT_DIGIT: begin
                     cmd.rep_digit = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Synthetic release that follows an injected press.
         S_WR2: begin
            cmd.wr_synth = 1'b1;
            state_in     = S_STOPCHK;
         end
         // Automatic stop when the store nears capacity.
         S_STOPCHK: begin
            if (status.stop_due && status.rec && !status.play) begin
               cmd.clr_rec = 1'b1;
               state_in    = S_TRIM_RD;
            end else begin
               state_in = S_EMIT_STAT;
            end
         end
         // Trim trailing presses, one entry per read and check.
         S_TRIM_RD: begin
            if (status.count_zero) begin
               state_in = S_EMIT_STAT;
            end else begin
               cmd.rd_tail = 1'b1;
               state_in    = S_TRIM_CHK;
            end
         end
         S_TRIM_CHK: begin
            if (status.tail_press) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_TRIM_RD;
            end else begin
               state_in = S_EMIT_STAT;
            end
         end
         S_EMIT_STAT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_STATUS;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_PLAY_MARK1: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_RELEASE;
               cmd.ptr_clear = 1'b1;
               state_in      = S_PLAY_RD;
            end
         end
         // First store read of the replay.
         S_PLAY_RD: begin
            if (status.play_done) begin
               state_in = S_PLAY_MARK2;
            end else begin
               cmd.rd_play = 1'b1;
               state_in    = S_PLAY_OUT;
            end
         end
         // Each transfer of an event overlaps the read of the next one.
         S_PLAY_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_EVENT;
               if (status.play_done) begin
                  state_in = S_PLAY_MARK2;
               end else begin
                  cmd.rd_play = 1'b1;
               end
            end
         end
         S_PLAY_MARK2: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_RELEASE;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/kmr_datapath.sv =====
// Datapath of the key macro recorder and replayer: item register, event store,
// record and repeat counters, flags, configuration registers and result register.
// Depends on kmr_pkg; driven by kmr_ctrl through the command struct.
`timescale 1ns / 1ps

module kmr_datapath #(
   parameter int STORE_DEPTH = kmr_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kmr_pkg::cmd_type                     cmd,
   output kmr_pkg::status_type                  status,
   input  logic [kmr_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic [3:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [kmr_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [kmr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [kmr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [kmr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata
);
   import kmr_pkg::*;

   localparam int CountWidth = $clog2(STORE_DEPTH + 1);
   localparam int AddrWidth  = $clog2(STORE_DEPTH);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(STORE_DEPTH);
   localparam logic [5:0] Depth6 = 6'(STORE_DEPTH);

   // Configuration registers.
   logic [5:0]  cap_ff;
   logic [15:0] max_rep_ff;
   logic [7:0]  pmask_ff;
   logic [7:0]  wmask_ff;
   logic [7:0]  imask_ff;
   logic        csr_we;

   assign csr_we = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAPACITY_RESET;
         max_rep_ff <= MAX_REPEATS_RESET;
         pmask_ff   <= PRESSED_RESET;
         wmask_ff   <= WAS_PRESSED_RESET;
         imask_ff   <= INJECTED_RESET;
      end else if (csr_we) begin
         unique case (csr_paddr[4:2])
            REG_CAPACITY:    cap_ff     <= csr_pwdata[5:0];
            REG_MAX_REPEATS: max_rep_ff <= csr_pwdata[15:0];
            REG_PRESSED:     pmask_ff   <= csr_pwdata[7:0];
            REG_WAS_PRESSED: wmask_ff   <= csr_pwdata[7:0];
            REG_INJECTED:    imask_ff   <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_CAPACITY:    csr_prdata = {26'd0, cap_ff};
         REG_MAX_REPEATS: csr_prdata = {16'd0, max_rep_ff};
         REG_PRESSED:     csr_prdata = {24'd0, pmask_ff};
         REG_WAS_PRESSED: csr_prdata = {24'd0, wmask_ff};
         REG_INJECTED:    csr_prdata = {24'd0, imask_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Item register, loaded at the input transfer.
   logic [3:0]  item_action_ff;
   logic [15:0] item_code_ff;
   logic [7:0]  item_row_ff;
   logic [7:0]  item_col_ff;
   logic [7:0]  item_state_ff;
   logic [3:0]  item_digit_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap_item) begin
         item_action_ff <= req_tuser;
         item_code_ff   <= req_tdata[15:0];
         item_row_ff    <= req_tdata[23:16];
         item_col_ff    <= req_tdata[31:24];
         item_state_ff  <= req_tdata[39:32];
         item_digit_ff  <= req_tdata[43:40];
      end
   end

   // Flags, record count and replay pointer.
   logic                  rec_ff;
   logic                  play_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] ptr_ff;
   logic                  store_open;
   logic                  wr_en;

   assign store_open = (count_ff < DepthCount);
   assign wr_en      = (cmd.wr_event || cmd.wr_synth) && store_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff   <= 1'b0;
         play_ff  <= 1'b0;
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         if (cmd.set_rec) begin
            rec_ff <= 1'b1;
         end else if (cmd.clr_rec) begin
            rec_ff <= 1'b0;
         end
         if (cmd.set_play) begin
            play_ff <= 1'b1;
         end else if (cmd.clr_play) begin
            play_ff <= 1'b0;
         end
         priority if (cmd.cnt_clear) begin
            count_ff <= '0;
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CountWidth'(1);
         end else if (wr_en) begin
            count_ff <= count_ff + CountWidth'(1);
         end else begin
            count_ff <= count_ff;
         end
         if (cmd.ptr_clear) begin
            ptr_ff <= '0;
         end else if (cmd.rd_play) begin
            ptr_ff <= ptr_ff + CountWidth'(1);
         end
      end
   end

   // Repeat counter with decimal entry and saturation.
   logic [15:0] rep_ff;
   logic [3:0]  digit_val;
   logic [19:0] rep_times_ten;
   logic [19:0] rep_digit_sum;

   assign digit_val     = (item_digit_ff > DIGIT_MAX) ? DIGIT_MAX : item_digit_ff;
   assign rep_times_ten = {1'b0, rep_ff, 3'd0} + {3'd0, rep_ff, 1'b0};
   assign rep_digit_sum = rep_times_ten + {16'd0, digit_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_ff <= '0;
      end else begin
         priority if (cmd.rep_clear) begin
            rep_ff <= '0;
         end else if (cmd.rep_dec) begin
            rep_ff <= rep_ff - 16'd1;
         end else if (cmd.rep_min1) begin
            if (rep_ff == 16'd0) begin
               rep_ff <= 16'd1;
            end
         end else if (cmd.rep_digit) begin
            rep_ff <= (rep_digit_sum > {4'd0, max_rep_ff}) ? max_rep_ff :
                      rep_digit_sum[15:0];
         end else begin
            rep_ff <= rep_ff;
         end
      end
   end

   // Event store: one write port at the record count, one registered read port.
   entry_type             event_store_ff [STORE_DEPTH];
   entry_type             rd_data_ff;
   entry_type             wr_entry;
   logic [CountWidth-1:0] tail_count;
   logic [AddrWidth-1:0]  rd_addr;
   logic                  rd_en;

   assign tail_count = count_ff - CountWidth'(1);
   assign rd_addr    = cmd.rd_tail ? tail_count[AddrWidth-1:0] : ptr_ff[AddrWidth-1:0];
   assign rd_en      = cmd.rd_tail || cmd.rd_play;

   always_comb begin
      wr_entry.code = item_code_ff;
      wr_entry.row  = item_row_ff;
      wr_entry.col  = item_col_ff;
      wr_entry.st   = cmd.wr_synth ? (wmask_ff | imask_ff) : item_state_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         event_store_ff[count_ff[AddrWidth-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= event_store_ff[rd_addr];
      end
   end

   // Status toward the controller.
   logic [5:0] eff_cap;
   logic [5:0] count6;

   assign eff_cap = (cap_ff > Depth6) ? Depth6 : cap_ff;
   assign count6  = 6'(count_ff);

   // Result register: one slot between the block and the result channel.
   logic        out_valid_ff;
   kind_type    out_kind_ff;
   entry_type   out_entry_ff;
   logic        out_rec_ff;
   logic        out_play_ff;
   logic [15:0] out_rep_ff;
   logic [5:0]  out_count_ff;
   logic        out_last_ff;
   logic        out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      status.action        = item_action_ff;
      status.enabled       = (eff_cap >= 6'd2);
      status.rec           = rec_ff;
      status.play          = play_ff;
      status.rep_zero      = (rep_ff == 16'd0);
      status.count_zero    = (count_ff == '0);
      status.item_press    = is_press(item_state_ff, pmask_ff, wmask_ff);
      status.item_release  = is_release(item_state_ff, pmask_ff, wmask_ff);
      status.item_injected = |(item_state_ff & imask_ff);
      status.stop_due      = ({1'b0, count6} + 7'd1) >= {1'b0, eff_cap};
      status.tail_press    = is_press(rd_data_ff.st, pmask_ff, wmask_ff);
      status.play_done     = (ptr_ff == count_ff);
      status.out_free      = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result payload; events carry the stored state with the injected bits set.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_kind_ff  <= cmd.out_kind;
         out_last_ff  <= cmd.out_last;
         out_rec_ff   <= rec_ff;
         out_play_ff  <= play_ff;
         out_rep_ff   <= rep_ff;
         out_count_ff <= count6;
         if (cmd.out_kind == KIND_EVENT) begin
            out_entry_ff <= {rd_data_ff.code, rd_data_ff.row, rd_data_ff.col,
                             rd_data_ff.st | imask_ff};
         end else begin
            out_entry_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_count_ff, out_rep_ff, out_play_ff, out_rec_ff,
                        out_entry_ff.st, out_entry_ff.col, out_entry_ff.row,
                        out_entry_ff.code};

endmodule

// ===== design/key_macro_record_replay.sv =====
// An input is taken into the item register and decoded; a stored key event is written, with
// a synthetic release after an injected press, and a stop first trims trailing presses; a
// status result follows. Inputs are taken one at a time; a replaying tick instead streams
// its events through the event store's single read port, one event per cycle while the
// result channel does not stall. Reset is synchronous and active high and sets flags,
// counters and configuration registers. The store is not cleared; only written entries are read.
`timescale 1ns / 1ps

module key_macro_record_replay #(
   parameter int STORE_DEPTH = kmr_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // key_code[15:0], key_row[23:16], key_col[31:24], key_state[39:32], digit[43:40]
   input  logic [kmr_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // action[3:0]
   input  logic [3:0]                         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // out_key_code[15:0], out_row[23:16], out_col[31:24], out_state[39:32],
   // is_recording[40], is_replaying[41], repeats_left[57:42], stored_count[63:58]
   output logic [kmr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kmr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [kmr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [kmr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import kmr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The configuration port never waits.
   assign csr_pready = 1'b1;

   kmr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kmr_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

// ===== design/kmr_checker.sv =====
// Port-level checks for the key macro recorder and replayer.
// Watches the result channel of the top level; bound to it at the end of this file.
// Depends on kmr_pkg for the result kinds.
`timescale 1ns / 1ps

module kmr_checker #(
   parameter int STORE_DEPTH = kmr_pkg::STORE_DEPTH_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [kmr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [1:0]                         rsp_tuser,
   input logic                               rsp_tlast
);
   import kmr_pkg::*;

   // A stalled transfer keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   // A status result always closes its step, a replayed event never does.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_STATUS) |-> rsp_tlast)
      else $error("status result without last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EVENT) |-> !rsp_tlast)
      else $error("replayed event marked last");

   // Recording and replaying exclude each other.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[40] && rsp_tdata[41]))
      else $error("recording and replaying both set");

   // The record count never exceeds the store depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:58] <= 6'(STORE_DEPTH)))
      else $error("stored count beyond store depth");

endmodule

bind key_macro_record_replay kmr_checker #(
   .STORE_DEPTH (STORE_DEPTH)
) u_kmr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
